// File: hdl/odometry_stream_parser_macros.svh
// Assertion macros shared by the odometry stream parser modules.
`ifndef ODOMETRY_STREAM_PARSER_MACROS_SVH
`define ODOMETRY_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is held.
`define OSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is held.
`define OSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/osp_pkg.sv
// Package: shared types and constants of the odometry stream parser.
`timescale 1ns / 1ps
package osp_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'd19;

  localparam logic [7:0] DIST_ID_RST  = 8'd19;
  localparam logic [7:0] ANGLE_ID_RST = 8'd20;
  localparam logic [7:0] BUMPS_ID_RST = 8'd7;

  // Request opcodes
  localparam logic OP_STREAM = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUMPS_ID = 2'd2;

  // Bumper bit positions in the bumps byte
  localparam int unsigned LEFT_BUMP_BIT  = 1;
  localparam int unsigned RIGHT_BUMP_BIT = 0;

  localparam int unsigned SUM_WIDTH_DEF  = 32;
  localparam int unsigned CMDQ_DEPTH_DEF = 4;
  localparam int unsigned OUTQ_DEPTH     = 2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] stream_byte;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] distance_total;
    logic signed [31:0] angle_total;
    logic               left_bump;
    logic               right_bump;
  } out_res_t;

  // Command from the parser to the accumulator
  typedef struct packed {
    logic        is_clear;
    logic [15:0] distance;
    logic [15:0] angle;
    logic [1:0]  bumps;
    logic        bumps_seen;
  } cmd_t;

  // Queue status seen by its consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hdl/odometry_stream_parser.sv
// Top level of the odometry stream parser: front parser, command queue, back end.
//
//   channel | direction | handshake                 | payload
//   in      | in        | in_push / in_full         | in_req (opcode, stream_byte)
//   out     | out       | out_pop / out_empty       | out_res (totals, bumper bits)
//   cfg     | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One request is taken per cycle while in_full is low; the parser handles each byte as it is taken.
// A finished packet is written into the command queue as its last byte is taken;
// the accumulator then applies it and pushes the result into the result queue.
// in_full rises only when the command queue is full, which happens only while
// results are not popped; cfg_ready is always high.
// Synchronous active-low reset; no clearing pass, usable the cycle after reset.
`timescale 1ns / 1ps
module odometry_stream_parser #(
  parameter int unsigned SUM_WIDTH  = osp_pkg::SUM_WIDTH_DEF,
  parameter int unsigned CMDQ_DEPTH = osp_pkg::CMDQ_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  osp_pkg::in_req_t              in_req,
  output logic                          in_full,
  output logic                          out_empty,
  output osp_pkg::out_res_t             out_res,
  input  logic                          out_pop,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [osp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import osp_pkg::*;

  logic    req_take;
  logic    cmd_push, cmd_pop;
  cmd_t    cmd_in, cmd_out;
  q_stat_t cmdq_stat, res_stat;

  assign cfg_ready = 1'b1;
  assign in_full   = cmdq_stat.full;
  assign req_take  = in_push && !cmdq_stat.full;
  assign out_empty = res_stat.empty;

  osp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_take  (req_take),
    .req       (in_req),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  osp_fifo #(
    .item_t (cmd_t),
    .DEPTH  (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .stat  (cmdq_stat)
  );

  osp_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd_out),
    .cmd_stat (cmdq_stat),
    .cmd_pop  (cmd_pop),
    .res_pop  (out_pop),
    .res      (out_res),
    .res_stat (res_stat)
  );

endmodule

// File: hdl/osp_fifo.sv
// Small register queue used between the parser stages and at the result side.
`timescale 1ns / 1ps
module osp_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  item_t          din,
  input  logic           pop,
  output item_t          dout,
  output osp_pkg::q_stat_t stat
);
  import osp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

`include "odometry_stream_parser_macros.svh"
  `OSP_ASSERT_NOW(a_count_bound, 1'b1, count_r <= FULL_CNT, "queue count over depth")
  `OSP_ASSERT_NEXT(a_push_fills, do_push && !do_pop, !stat.empty, "queue empty after push")
  `OSP_ASSERT_NOW(a_ptrs_full, stat.full, wr_ptr_r == rd_ptr_r, "pointers apart when full")

endmodule

// File: hdl/osp_front.sv
// Front end: byte parser that turns the stream into clear and packet commands.
`timescale 1ns / 1ps
module osp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr,
  input  logic [osp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic                               req_take,
  input  osp_pkg::in_req_t                   req,
  output logic                               cmd_push,
  output osp_pkg::cmd_t                      cmd
);
  import osp_pkg::*;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_ID   = 3'd2;
  localparam logic [2:0] PH_HI   = 3'd3;
  localparam logic [2:0] PH_LO   = 3'd4;
  localparam logic [2:0] PH_BUMP = 3'd5;

  localparam logic REC_DIST  = 1'b0;
  localparam logic REC_ANGLE = 1'b1;

  logic [7:0]  dist_id_r, angle_id_r, bumps_id_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic        rec_r, rec_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] pdist_r, pdist_nxt;
  logic [15:0] pang_r, pang_nxt;
  logic [1:0]  pbump_r, pbump_nxt;
  logic        bseen_r, bseen_nxt;
  logic        pkt_done;
  logic [7:0]  b;
  logic [7:0]  rem_dec;

  assign b       = req.stream_byte;
  assign rem_dec = rem_r - 8'd1;

  // Hold the record ID registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_id_r  <= DIST_ID_RST;
      angle_id_r <= ANGLE_ID_RST;
      bumps_id_r <= BUMPS_ID_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_DIST_ID:  dist_id_r  <= cfg_data;
        CFG_ANGLE_ID: angle_id_r <= cfg_data;
        CFG_BUMPS_ID: bumps_id_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the parse on each stream byte
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    rec_nxt   = rec_r;
    hold_nxt  = hold_r;
    pdist_nxt = pdist_r;
    pang_nxt  = pang_r;
    pbump_nxt = pbump_r;
    bseen_nxt = bseen_r;
    pkt_done  = 1'b0;
    if (req_take && (req.opcode == OP_STREAM)) begin
      unique case (phase_r)
        PH_LEN: begin
          rem_nxt   = b;
          pdist_nxt = '0;
          pang_nxt  = '0;
          pbump_nxt = '0;
          bseen_nxt = 1'b0;
          if (b == 8'd0) begin
            pkt_done  = 1'b1;
            phase_nxt = PH_HUNT;
          end else begin
            phase_nxt = PH_ID;
          end
        end
        PH_ID: begin
          if (b == dist_id_r || b == angle_id_r) begin
            if (rem_r < 8'd3) begin
              phase_nxt = PH_HUNT;
            end else begin
              rec_nxt   = (b == dist_id_r) ? REC_DIST : REC_ANGLE;
              rem_nxt   = rem_dec;
              phase_nxt = PH_HI;
            end
          end else if (b == bumps_id_r) begin
            if (rem_r < 8'd2) begin
              phase_nxt = PH_HUNT;
            end else begin
              rem_nxt   = rem_dec;
              phase_nxt = PH_BUMP;
            end
          end else begin
            // Drop the packet on an unknown ID
            phase_nxt = PH_HUNT;
          end
        end
        PH_HI: begin
          hold_nxt  = b;
          rem_nxt   = rem_dec;
          phase_nxt = PH_LO;
        end
        PH_LO: begin
          if (rec_r == REC_DIST) begin
            pdist_nxt = {hold_r, b};
          end else begin
            pang_nxt = {hold_r, b};
          end
          rem_nxt   = rem_dec;
          pkt_done  = (rem_dec == 8'd0);
          phase_nxt = pkt_done ? PH_HUNT : PH_ID;
        end
        PH_BUMP: begin
          pbump_nxt = b[1:0];
          bseen_nxt = 1'b1;
          rem_nxt   = rem_dec;
          pkt_done  = (rem_dec == 8'd0);
          phase_nxt = pkt_done ? PH_HUNT : PH_ID;
        end
        default: begin
          // Hunt for the header byte
          phase_nxt = (b == HEADER_BYTE) ? PH_LEN : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      rem_r   <= '0;
      rec_r   <= REC_DIST;
      hold_r  <= '0;
      pdist_r <= '0;
      pang_r  <= '0;
      pbump_r <= '0;
      bseen_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      rec_r   <= rec_nxt;
      hold_r  <= hold_nxt;
      pdist_r <= pdist_nxt;
      pang_r  <= pang_nxt;
      pbump_r <= pbump_nxt;
      bseen_r <= bseen_nxt;
    end
  end

  // Issue a command on a clear or a finished packet
  assign cmd_push       = req_take && ((req.opcode == OP_CLEAR) || pkt_done);
  assign cmd.is_clear   = (req.opcode == OP_CLEAR);
  assign cmd.distance   = pdist_nxt;
  assign cmd.angle      = pang_nxt;
  assign cmd.bumps      = pbump_nxt;
  assign cmd.bumps_seen = bseen_nxt;

endmodule

// File: hdl/osp_back.sv
// Back end: applies commands to the running totals and queues the results.
`timescale 1ns / 1ps
module osp_back #(
  parameter int unsigned SUM_WIDTH = osp_pkg::SUM_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  osp_pkg::cmd_t      cmd,
  input  osp_pkg::q_stat_t   cmd_stat,
  output logic               cmd_pop,
  input  logic               res_pop,
  output osp_pkg::out_res_t  res,
  output osp_pkg::q_stat_t   res_stat
);
  import osp_pkg::*;

  logic signed [SUM_WIDTH-1:0] dsum_r, dsum_nxt;
  logic signed [SUM_WIDTH-1:0] asum_r, asum_nxt;
  logic signed [SUM_WIDTH-1:0] dwide, awide;
  logic signed [15:0]          d16, a16;
  logic [1:0]                  bump_r, bump_nxt;
  logic                        stale_r, stale_nxt;
  logic                        go, res_push;
  out_res_t                    res_in;
  q_stat_t                     outq_stat;

  assign d16   = cmd.distance;
  assign a16   = cmd.angle;
  assign dwide = SUM_WIDTH'(d16);
  assign awide = SUM_WIDTH'(a16);

  // Take a queued command when it is a clear or the result queue has room for it
  assign go       = !cmd_stat.empty && (cmd.is_clear || !outq_stat.full);
  assign cmd_pop  = go;
  assign res_push = go && !cmd.is_clear;

  // Update the totals
  always_comb begin
    dsum_nxt  = dsum_r;
    asum_nxt  = asum_r;
    bump_nxt  = bump_r;
    stale_nxt = stale_r;
    if (go) begin
      if (cmd.is_clear) begin
        dsum_nxt  = '0;
        asum_nxt  = '0;
        stale_nxt = 1'b1;
      end else begin
        dsum_nxt  = stale_r ? dwide : dsum_r + dwide;
        asum_nxt  = stale_r ? awide : asum_r + awide;
        bump_nxt  = cmd.bumps_seen ? cmd.bumps : bump_r;
        stale_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsum_r  <= '0;
      asum_r  <= '0;
      bump_r  <= '0;
      stale_r <= 1'b1;
    end else begin
      dsum_r  <= dsum_nxt;
      asum_r  <= asum_nxt;
      bump_r  <= bump_nxt;
      stale_r <= stale_nxt;
    end
  end

  // Build the result from the updated totals
  assign res_in.distance_total = 32'(dsum_nxt);
  assign res_in.angle_total    = 32'(asum_nxt);
  assign res_in.left_bump      = bump_nxt[LEFT_BUMP_BIT];
  assign res_in.right_bump     = bump_nxt[RIGHT_BUMP_BIT];

  osp_fifo #(
    .item_t (out_res_t),
    .DEPTH  (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .pop   (res_pop),
    .dout  (res),
    .stat  (outq_stat)
  );

  assign res_stat = outq_stat;

`include "odometry_stream_parser_macros.svh"
  `OSP_ASSERT_NEXT(a_clear_stale, go && cmd.is_clear, stale_r, "clear left data fresh")
  `OSP_ASSERT_NEXT(a_pkt_fresh, go && !cmd.is_clear, !stale_r, "packet left data stale")
  `OSP_ASSERT_NEXT(a_clear_zero, go && cmd.is_clear, dsum_r == '0 && asum_r == '0, "clear kept totals")
  `OSP_ASSERT_NOW(a_no_push_full, res_push, !outq_stat.full, "result pushed into full queue")

endmodule
